>>> hdl/fragment_retransmit_tracker_top_defines.svh
// Assertion helpers for the tracker top module.
`ifndef FRAGMENT_RETRANSMIT_TRACKER_TOP_DEFINES_SVH
`define FRAGMENT_RETRANSMIT_TRACKER_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define FRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define FRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/frt_pkg.sv
`timescale 1ns / 1ps
package frt_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] MPS_RESET    = 16'd1024;
  localparam logic [15:0] RTI_RESET    = 16'd100;
  localparam logic [7:0]  MAXATT_RESET = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PACKET_SIZE     = 2'd0,
    CFG_RETRANSMIT_INTERVAL = 2'd1,
    CFG_MAX_ATTEMPTS        = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_SEND      = 3'd0,
    EV_RESEND    = 3'd1,
    EV_PARTIAL   = 3'd2,
    EV_DELIVERED = 3'd3,
    EV_UNKNOWN   = 3'd4,
    EV_FULL      = 3'd5
  } event_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [31:0] pkg_id;
    logic [31:0] msg_id;
    logic [5:0]  frag_idx;
    logic [6:0]  frag_tot;
    logic [31:0] sent;
    logic [7:0]  att;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One result item.
  typedef struct packed {
    event_t      ev;
    logic [31:0] pkg_id;
    logic [31:0] msg_id;
    logic [5:0]  frag_idx;
    logic [6:0]  frag_tot;
    logic        last;
  } res_t;

endpackage

>>> hdl/frt_if.sv
`timescale 1ns / 1ps
// Input item channel.
interface frt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] message_id;
  logic [15:0] payload_length;
  logic [31:0] ack_package_id;

  modport source (output valid, kind, message_id, payload_length, ack_package_id,
                  input ready);
  modport sink (input valid, kind, message_id, payload_length, ack_package_id,
                output ready);
endinterface

// Result item channel.
interface frt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] package_id;
  logic [31:0] message_id_out;
  logic [5:0]  fragment_index;
  logic [6:0]  fragment_total;
  logic        last;

  modport source (output valid, event_res, package_id, message_id_out, fragment_index,
                  fragment_total, last, input ready);
  modport sink (input valid, event_res, package_id, message_id_out, fragment_index,
                fragment_total, last, output ready);
endinterface

>>> hdl/fragment_retransmit_tracker_top.sv
`timescale 1ns / 1ps
// Sequence: a submit first divides the payload length into a fragment count, checks it against
// the free entries, then fills table entries; an ack searches the entries for the id (read, then
// evaluate) and then for any other fragment of the same message; a tick reads, then evaluates,
// each entry and then emits any held resend. Items are taken one at a time, paced by the single
// read port of the entry memory; results wait in one output register.
// Reset: synchronous, active low; clears valid bits, counters, ids and registers to defaults.
`include "fragment_retransmit_tracker_top_defines.svh"
module fragment_retransmit_tracker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [frt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [frt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  frt_in_if.sink                        in_ch,
  frt_out_if.source                     out_ch
);

  localparam logic [frt_pkg::IDX_W-1:0] LAST_IDX =
    frt_pkg::IDX_W'(frt_pkg::TABLE_ENTRIES - 1);
  localparam logic [frt_pkg::CNT_W-1:0] ENTRIES_CNT =
    frt_pkg::CNT_W'(frt_pkg::TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_CHK, ST_FULL, ST_SUB,
    ST_ARD, ST_AEV, ST_MRD, ST_MEV, ST_AOUT,
    ST_TRD, ST_TEV, ST_TFL
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] mps_r;
  logic [15:0] rti_r;
  logic [7:0]  maxatt_r;

  // Table bookkeeping.
  logic [frt_pkg::TABLE_ENTRIES-1:0] vld_r;
  logic [frt_pkg::CNT_W-1:0]         cnt_r;
  logic [31:0]                       npid_r;
  logic [31:0]                       tick_r;

  // Per-item working registers.
  logic [frt_pkg::IDX_W-1:0] idx_r;
  logic [31:0]               msg_r;
  logic [31:0]               ack_r;
  logic [15:0]               num_r;
  logic [16:0]               rem_r;
  logic [15:0]               quo_r;
  logic [3:0]                step_r;
  logic [5:0]                frag_r;
  logic [6:0]                tot_r;
  frt_pkg::entry_t           hit_r;
  logic                      hit_found_r;
  logic                      remain_r;
  frt_pkg::res_t             pend_r;
  logic                      pend_vld_r;

  // Output register.
  frt_pkg::res_t out_res_r;
  logic          out_vld_r;

  // Memory ports.
  logic [frt_pkg::ENTRY_W-1:0] rdata;
  frt_pkg::entry_t             rd_e;
  frt_pkg::entry_t             wr_e;
  logic                        ram_we;

  // Combinational decisions.
  logic        can_emit;
  logic [15:0] den;
  logic [16:0] trial;
  logic [16:0] total17;
  logic [16:0] free17;
  logic [31:0] age;
  logic        expired;
  logic        drop;
  logic        resend_go;
  logic        sub_go;
  logic        sub_last;
  frt_pkg::res_t resend_res;
  frt_pkg::res_t pend_last;
  logic        out_load;
  logic        out_is_send;
  logic        frag_ok;

  frt_ram #(
    .WIDTH (frt_pkg::ENTRY_W),
    .DEPTH (frt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (wr_e),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_e     = frt_pkg::entry_t'(rdata);
  assign can_emit = !out_vld_r || out_ch.ready;

  // Restoring division step and the fragment count check.
  always_comb begin
    den     = (mps_r == 16'd0) ? 16'd1 : mps_r;
    trial   = {rem_r[15:0], num_r[15]};
    total17 = {1'b0, quo_r} + {16'd0, (rem_r != 17'd0)};
    if (total17 == 17'd0) begin
      total17 = 17'd1;
    end
    free17 = {{(17 - frt_pkg::CNT_W){1'b0}}, ENTRIES_CNT - cnt_r};
  end

  // Scan decisions for ticks and submits.
  always_comb begin
    age       = tick_r - rd_e.sent;
    expired   = vld_r[idx_r] && (age >= {16'd0, rti_r});
    drop      = expired && (rd_e.att >= maxatt_r);
    resend_go = (state_r == ST_TEV) && expired && !drop && (!pend_vld_r || can_emit);
    sub_go    = (state_r == ST_SUB) && !vld_r[idx_r] && can_emit;
    sub_last  = ({1'b0, frag_r} == (tot_r - 7'd1));
    resend_res = '{ev: frt_pkg::EV_RESEND, pkg_id: rd_e.pkg_id, msg_id: rd_e.msg_id,
                   frag_idx: rd_e.frag_idx, frag_tot: rd_e.frag_tot, last: 1'b0};
  end

  // Output register load: one result enters whenever a state emits.
  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
    case (state_r)
      ST_FULL, ST_AOUT: out_load = can_emit;
      ST_SUB:           out_load = sub_go;
      ST_TEV:           out_load = resend_go && pend_vld_r;
      ST_TFL:           out_load = pend_vld_r && can_emit;
      default:          out_load = 1'b0;
    endcase
  end

  // Memory write: new fragment on submit, refreshed entry on resend.
  always_comb begin
    ram_we = sub_go || resend_go;
    if (state_r == ST_SUB) begin
      wr_e = '{pkg_id: npid_r, msg_id: msg_r, frag_idx: frag_r, frag_tot: tot_r,
               sent: tick_r, att: 8'd1};
    end else begin
      wr_e      = rd_e;
      wr_e.sent = tick_r;
      wr_e.att  = (rd_e.att == 8'hFF) ? rd_e.att : rd_e.att + 8'd1;
    end
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mps_r       <= frt_pkg::MPS_RESET;
      rti_r       <= frt_pkg::RTI_RESET;
      maxatt_r    <= frt_pkg::MAXATT_RESET;
      vld_r       <= '0;
      cnt_r       <= '0;
      npid_r      <= '0;
      tick_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
      hit_found_r <= 1'b0;
      remain_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_we) begin
        case (frt_pkg::cfg_idx_t'(cfg_idx))
          frt_pkg::CFG_MAX_PACKET_SIZE:     mps_r    <= cfg_wdata;
          frt_pkg::CFG_RETRANSMIT_INTERVAL: rti_r    <= cfg_wdata;
          frt_pkg::CFG_MAX_ATTEMPTS:        maxatt_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (in_ch.valid) begin
            msg_r <= in_ch.message_id;
            ack_r <= in_ch.ack_package_id;
            case (frt_pkg::kind_t'(in_ch.kind))
              frt_pkg::KIND_SUBMIT: begin
                num_r   <= in_ch.payload_length;
                rem_r   <= '0;
                quo_r   <= '0;
                step_r  <= '0;
                state_r <= ST_DIV;
              end
              frt_pkg::KIND_ACK: begin
                hit_found_r <= 1'b0;
                state_r     <= ST_ARD;
              end
              frt_pkg::KIND_TICK: begin
                tick_r  <= tick_r + 32'd1;
                state_r <= ST_TRD;
              end
              default: ;
            endcase
          end
        end

        // One quotient bit per cycle.
        ST_DIV: begin
          num_r  <= {num_r[14:0], 1'b0};
          step_r <= step_r + 4'd1;
          if (trial >= {1'b0, den}) begin
            rem_r <= trial - {1'b0, den};
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[14:0], 1'b0};
          end
          if (step_r == 4'd15) begin
            state_r <= ST_CHK;
          end
        end

        ST_CHK: begin
          frag_r <= '0;
          tot_r  <= total17[6:0];
          if (total17 > free17) begin
            state_r <= ST_FULL;
          end else begin
            state_r <= ST_SUB;
          end
        end

        ST_FULL: begin
          if (can_emit) begin
            out_res_r <= '{ev: frt_pkg::EV_FULL, pkg_id: 32'd0, msg_id: msg_r,
                           frag_idx: 6'd0, frag_tot: 7'd0, last: 1'b1};
            state_r   <= ST_IDLE;
          end
        end

        // Fill the lowest free entries in order.
        ST_SUB: begin
          if (vld_r[idx_r]) begin
            idx_r <= idx_r + 1'b1;
          end else if (sub_go) begin
            vld_r[idx_r] <= 1'b1;
            cnt_r        <= cnt_r + 1'b1;
            npid_r       <= npid_r + 32'd1;
            out_res_r    <= '{ev: frt_pkg::EV_SEND, pkg_id: npid_r, msg_id: msg_r,
                              frag_idx: frag_r, frag_tot: tot_r, last: sub_last};
            if (sub_last) begin
              state_r <= ST_IDLE;
            end else begin
              frag_r <= frag_r + 6'd1;
              idx_r  <= idx_r + 1'b1;
            end
          end
        end

        ST_ARD: state_r <= ST_AEV;

        // Search for the acknowledged package id.
        ST_AEV: begin
          if (vld_r[idx_r] && rd_e.pkg_id == ack_r) begin
            hit_r        <= rd_e;
            hit_found_r  <= 1'b1;
            remain_r     <= 1'b0;
            vld_r[idx_r] <= 1'b0;
            cnt_r        <= cnt_r - 1'b1;
            idx_r        <= '0;
            state_r      <= ST_MRD;
          end else if (idx_r == LAST_IDX) begin
            state_r <= ST_AOUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_ARD;
          end
        end

        ST_MRD: state_r <= ST_MEV;

        // Look for any other fragment of the same message.
        ST_MEV: begin
          if (vld_r[idx_r] && rd_e.msg_id == hit_r.msg_id) begin
            remain_r <= 1'b1;
            state_r  <= ST_AOUT;
          end else if (idx_r == LAST_IDX) begin
            state_r <= ST_AOUT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_MRD;
          end
        end

        ST_AOUT: begin
          if (can_emit) begin
            if (!hit_found_r) begin
              out_res_r <= '{ev: frt_pkg::EV_UNKNOWN, pkg_id: ack_r, msg_id: 32'd0,
                             frag_idx: 6'd0, frag_tot: 7'd0, last: 1'b1};
            end else begin
              out_res_r <= '{ev: remain_r ? frt_pkg::EV_PARTIAL : frt_pkg::EV_DELIVERED,
                             pkg_id: ack_r, msg_id: hit_r.msg_id,
                             frag_idx: hit_r.frag_idx, frag_tot: hit_r.frag_tot,
                             last: 1'b1};
            end
            state_r <= ST_IDLE;
          end
        end

        ST_TRD: state_r <= ST_TEV;

        // Age check; a resend is held in a pending register until the next one, so the final one can carry last.
        ST_TEV: begin
          if (drop) begin
            vld_r[idx_r] <= 1'b0;
            cnt_r        <= cnt_r - 1'b1;
          end
          if (resend_go) begin
            if (pend_vld_r) begin
              out_res_r <= pend_r;
            end
            pend_r     <= resend_res;
            pend_vld_r <= 1'b1;
          end
          if (!expired || drop || resend_go) begin
            if (idx_r == LAST_IDX) begin
              state_r <= ST_TFL;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_TRD;
            end
          end
        end

        ST_TFL: begin
          if (!pend_vld_r) begin
            state_r <= ST_IDLE;
          end else if (can_emit) begin
            out_res_r  <= pend_last;
            pend_vld_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Port drive.
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_vld_r;
  assign out_ch.event_res      = out_res_r.ev;
  assign out_ch.package_id     = out_res_r.pkg_id;
  assign out_ch.message_id_out = out_res_r.msg_id;
  assign out_ch.fragment_index = out_res_r.frag_idx;
  assign out_ch.fragment_total = out_res_r.frag_tot;
  assign out_ch.last           = out_res_r.last;

  // Terms for the fragment range check.
  assign out_is_send = out_vld_r &&
                       (out_res_r.ev == frt_pkg::EV_SEND || out_res_r.ev == frt_pkg::EV_RESEND);
  assign frag_ok     = ({1'b0, out_res_r.frag_idx} < out_res_r.frag_tot);

  // The occupancy count tracks the valid bits.
  `FRT_ASSERT(a_cnt_matches, cnt_r == frt_pkg::CNT_W'($countones(vld_r)), "count drift")
  // Memory writes happen only while filling or resending.
  `FRT_ASSERT(a_we_state, ram_we |-> (state_r == ST_SUB || state_r == ST_TEV), "stray write")
  // A send or resend names a fragment inside its message.
  `FRT_ASSERT(a_frag_range, out_is_send |-> frag_ok, "fragment index out of range")

endmodule

>>> hdl/frt_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module frt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
